// File: rtl/egcd_pkg.sv
// Shared types and constants for the extended GCD core.
// Used by egcd_divider and extended_gcd_bezout_core; depends on nothing.
`timescale 1ns / 1ps

package egcd_pkg;

    // Fixed field widths of the stream payloads.
    localparam int unsigned OPND_W  = 16;
    localparam int unsigned GCD_W   = 16;
    localparam int unsigned COEFF_W = 17;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 56;

    // Saturation value of the step counter.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // Status returned by the divider to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/extended_gcd_bezout_core.sv
// Each division runs bit-serially through one shared divider, one quotient bit a cycle.
// Throughput: one request at a time; a new one is taken after the result is delivered.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle.
`timescale 1ns / 1ps

module extended_gcd_bezout_core #(
    parameter int unsigned OPERAND_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] first_operand, [31:16] second_operand
    input  logic [egcd_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] gcd_value, [32:16] coeff_first, [49:33] coeff_second,
    // [54:50] step_count, [55] zero
    output logic [egcd_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = OPERAND_WIDTH + 2;

    egcd_pkg::state_t state_reg, state_next;

    logic [W-1:0]                     a_reg, a_next;
    logic [W-1:0]                     b_reg, b_next;
    logic signed [CW-1:0]             cu_reg, cu_next, cup_reg, cup_next;
    logic signed [CW-1:0]             cv_reg, cv_next, cvp_reg, cvp_next;
    logic [egcd_pkg::COUNT_W-1:0]     steps_reg, steps_next;
    logic [egcd_pkg::GCD_W-1:0]       res_gcd_reg, res_gcd_next;
    logic signed [egcd_pkg::COEFF_W-1:0] res_u_reg, res_u_next;
    logic signed [egcd_pkg::COEFF_W-1:0] res_v_reg, res_v_next;

    logic                  div_start;
    logic [W-1:0]          div_rem;
    logic signed [CW-1:0]  div_prod_u;
    logic signed [CW-1:0]  div_prod_v;
    egcd_pkg::div_status_t div_stat;

    logic [egcd_pkg::OPND_W-1:0] in_first, in_second;

    assign in_first  = s_tdata[15:0];
    assign in_second = s_tdata[31:16];

    // Shared divider: computes a / b and q * u, q * v in one pass.
    // The dividend is the next operand value, so a division started together
    // with the shift to (divisor, remainder) works on the new pair.
    egcd_divider #(
        .OPW (W),
        .CFW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_next),
        .divisor  (b_reg),
        .coeff_u  (cu_reg),
        .coeff_v  (cv_reg),
        .rem      (div_rem),
        .prod_u   (div_prod_u),
        .prod_v   (div_prod_v),
        .status   (div_stat)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            egcd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = egcd_pkg::ST_CHECK;
            end
            egcd_pkg::ST_CHECK:
            begin
                state_next = (b_reg == '0) ? egcd_pkg::ST_OUT : egcd_pkg::ST_DIV;
            end
            egcd_pkg::ST_DIV:
            begin
                if (div_stat.done)
                    state_next = egcd_pkg::ST_UPDATE;
            end
            egcd_pkg::ST_UPDATE:
            begin
                state_next = (div_rem == '0) ? egcd_pkg::ST_OUT : egcd_pkg::ST_DIV;
            end
            egcd_pkg::ST_OUT:
            begin
                if (m_tready)
                    state_next = egcd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = egcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and divider start outputs.
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            egcd_pkg::ST_IDLE:   s_tready  = 1'b1;
            egcd_pkg::ST_CHECK:  div_start = (b_reg != '0);
            egcd_pkg::ST_DIV:    div_start = 1'b0;
            egcd_pkg::ST_UPDATE: div_start = (div_rem != '0);
            egcd_pkg::ST_OUT:    m_tvalid  = 1'b1;
            default:             s_tready  = 1'b0;
        endcase
    end

    // Operand, coefficient and result next values.
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        cu_next      = cu_reg;
        cup_next     = cup_reg;
        cv_next      = cv_reg;
        cvp_next     = cvp_reg;
        steps_next   = steps_reg;
        res_gcd_next = res_gcd_reg;
        res_u_next   = res_u_reg;
        res_v_next   = res_v_reg;
        case (state_reg)
            egcd_pkg::ST_IDLE:
            begin
                a_next     = W'(in_first);
                b_next     = W'(in_second);
                cu_next    = CW'(0);
                cup_next   = CW'(1);
                cv_next    = CW'(1);
                cvp_next   = CW'(0);
                steps_next = '0;
            end
            egcd_pkg::ST_CHECK:
            begin
                // Zero divisor: the first operand is the result.
                res_gcd_next = egcd_pkg::GCD_W'(a_reg);
                res_u_next   = egcd_pkg::COEFF_W'(1);
                res_v_next   = egcd_pkg::COEFF_W'(0);
            end
            egcd_pkg::ST_UPDATE:
            begin
                if (div_rem == '0)
                begin
                    res_gcd_next = egcd_pkg::GCD_W'(b_reg);
                    res_u_next   = egcd_pkg::COEFF_W'(cu_reg);
                    res_v_next   = egcd_pkg::COEFF_W'(cv_reg);
                end
                else
                begin
                    // Bezout update and shift of the pair to (divisor, remainder).
                    cu_next  = cup_reg - div_prod_u;
                    cup_next = cu_reg;
                    cv_next  = cvp_reg - div_prod_v;
                    cvp_next = cv_reg;
                    a_next   = b_reg;
                    b_next   = div_rem;
                    if (steps_reg != egcd_pkg::COUNT_MAX)
                        steps_next = steps_reg + 1'b1;
                end
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= egcd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        cu_reg      <= cu_next;
        cup_reg     <= cup_next;
        cv_reg      <= cv_next;
        cvp_reg     <= cvp_next;
        steps_reg   <= steps_next;
        res_gcd_reg <= res_gcd_next;
        res_u_reg   <= res_u_next;
        res_v_reg   <= res_v_next;
    end

    // Result packing.
    assign m_tdata = {1'b0, steps_reg, res_v_reg, res_u_reg, res_gcd_reg};

`ifndef SYNTH
    // The divider is only started when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A finished division is seen only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == egcd_pkg::ST_DIV))
        else $error("divider done outside the division state");

    // The remainder is always below the divisor when it is consumed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == egcd_pkg::ST_UPDATE) |-> (div_rem < b_reg))
        else $error("remainder not below divisor");

    // A request is never taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // A delivered result is followed by a return to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("no return to idle after result");
`endif

endmodule

// File: rtl/egcd_divider.sv
// Bit-serial restoring divider that also accumulates quotient * coefficient
// for both Bezout coefficients. Depends on egcd_pkg.
`timescale 1ns / 1ps

module egcd_divider #(
    parameter int unsigned OPW = 16,
    parameter int unsigned CFW = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [OPW-1:0]        dividend,
    input  logic [OPW-1:0]        divisor,
    input  logic signed [CFW-1:0] coeff_u,
    input  logic signed [CFW-1:0] coeff_v,
    output logic [OPW-1:0]        rem,
    output logic signed [CFW-1:0] prod_u,
    output logic signed [CFW-1:0] prod_v,
    output egcd_pkg::div_status_t status
);

    localparam int unsigned CNT_W = $clog2(OPW + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [OPW-1:0]        rem_reg, rem_next;
    logic [OPW-1:0]        dvd_reg, dvd_next;
    logic signed [CFW-1:0] acc_u_reg, acc_u_next;
    logic signed [CFW-1:0] acc_v_reg, acc_v_next;

    logic [OPW:0]          rem_sh;
    logic [OPW+1:0]        diff;
    logic                  qbit;

    // One restoring step: shift in the next dividend bit and trial-subtract.
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[OPW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, divisor};
        qbit   = ~diff[OPW+1];
    end

    // Step control and datapath next values.
    always_comb
    begin
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        acc_u_next = acc_u_reg;
        acc_v_next = acc_v_reg;
        if (start)
        begin
            cnt_next   = CNT_W'(OPW);
            busy_next  = 1'b1;
            rem_next   = '0;
            dvd_next   = dividend;
            acc_u_next = '0;
            acc_v_next = '0;
        end
        else if (busy_reg)
        begin
            cnt_next   = cnt_reg - 1'b1;
            rem_next   = qbit ? diff[OPW-1:0] : rem_sh[OPW-1:0];
            dvd_next   = {dvd_reg[OPW-2:0], 1'b0};
            // Horner form of q * coefficient, one quotient bit per cycle.
            acc_u_next = (acc_u_reg <<< 1) + (qbit ? coeff_u : '0);
            acc_v_next = (acc_v_reg <<< 1) + (qbit ? coeff_v : '0);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        acc_u_reg <= acc_u_next;
        acc_v_reg <= acc_v_next;
    end

    assign rem         = rem_reg;
    assign prod_u      = acc_u_reg;
    assign prod_v      = acc_v_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: tb/tb.sv
// Self-checking testbench for extended_gcd_bezout_core: GCD, Bezout coefficients and step count.
// Depends on egcd_pkg and the core; it holds its own predictor and a small scoreboard class.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned OPND_W     = egcd_pkg::OPND_W;
    localparam int unsigned GCD_W      = egcd_pkg::GCD_W;
    localparam int unsigned COEFF_W    = egcd_pkg::COEFF_W;
    localparam int unsigned COUNT_W    = egcd_pkg::COUNT_W;
    localparam int unsigned IN_DATA_W  = egcd_pkg::IN_DATA_W;
    localparam int unsigned OUT_DATA_W = egcd_pkg::OUT_DATA_W;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned RANDOM_REQUESTS = 1500;
    // Room for the worst request plus the longest sender gap and receiver stall,
    // taken several times over.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_CYCLES = 500;
    localparam int unsigned MAX_PRINTED = 40;

    // Expected result of one request, with its operands for messages.
    typedef struct {
        logic [OPND_W-1:0]         m;
        logic [OPND_W-1:0]         n;
        logic [GCD_W-1:0]          gcd;
        logic signed [COEFF_W-1:0] coeff_first;
        logic signed [COEFF_W-1:0] coeff_second;
        logic [COUNT_W-1:0]        steps;
    } bezout_t;

    // Scoreboard: predicts each accepted request and checks results in order.
    class egcd_scoreboard;
        bezout_t     pending_bezout[$];
        int unsigned mismatches;
        int unsigned requests_noted;
        int unsigned results_checked;
        int unsigned deepest_chain;
        int unsigned zero_operand_cases;

        function new();
            mismatches = 0;
            requests_noted = 0;
            results_checked = 0;
            deepest_chain = 0;
            zero_operand_cases = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Extended Euclid by repeated division, on 64-bit integers.
        function bezout_t solve_bezout(input logic [OPND_W-1:0] m, input logic [OPND_W-1:0] n);
            bezout_t         res;
            longint unsigned a;
            longint unsigned b;
            longint unsigned quot;
            longint unsigned rem;
            longint          cu;
            longint          cu_prev;
            longint          cv;
            longint          cv_prev;
            longint          nu;
            longint          nv;
            int unsigned     steps;
            a = m;
            b = n;
            cu = 0;
            cu_prev = 1;
            cv = 1;
            cv_prev = 0;
            steps = 0;
            res.m = m;
            res.n = n;
            // A zero divisor means no division at all.
            if (b == 0)
            begin
                res.gcd = a[GCD_W-1:0];
                res.coeff_first = COEFF_W'(1);
                res.coeff_second = '0;
                res.steps = '0;
                return res;
            end
            while (a % b != 0)
            begin
                quot = a / b;
                rem = a % b;
                nu = cu_prev - longint'(quot) * cu;
                nv = cv_prev - longint'(quot) * cv;
                cu_prev = cu;
                cv_prev = cv;
                cu = nu;
                cv = nv;
                a = b;
                b = rem;
                if (steps < egcd_pkg::COUNT_MAX)
                    steps++;
            end
            res.gcd = b[GCD_W-1:0];
            res.coeff_first = cu[COEFF_W-1:0];
            res.coeff_second = cv[COEFF_W-1:0];
            res.steps = steps[COUNT_W-1:0];
            return res;
        endfunction

        function void note_request(input logic [IN_DATA_W-1:0] data);
            bezout_t expected;
            expected = solve_bezout(data[OPND_W-1:0], data[2*OPND_W-1:OPND_W]);
            pending_bezout.push_back(expected);
            requests_noted++;
            if (expected.steps > deepest_chain)
                deepest_chain = expected.steps;
            if (expected.m == 0 || expected.n == 0)
                zero_operand_cases++;
        endfunction

        task check_result(input logic [OUT_DATA_W-1:0] data);
            bezout_t                   want;
            logic [GCD_W-1:0]          got_gcd;
            logic signed [COEFF_W-1:0] got_first;
            logic signed [COEFF_W-1:0] got_second;
            logic [COUNT_W-1:0]        got_steps;
            logic                      got_pad;
            got_gcd    = data[15:0];
            got_first  = data[32:16];
            got_second = data[49:33];
            got_steps  = data[54:50];
            got_pad    = data[55];
            if (pending_bezout.size() == 0)
            begin
                report($sformatf("result 0x%014h arrived with no request waiting", data));
                return;
            end
            want = pending_bezout.pop_front();
            results_checked++;
            if (got_gcd !== want.gcd)
                report($sformatf("m=%0d n=%0d gcd got %0d want %0d",
                                 want.m, want.n, got_gcd, want.gcd));
            if (got_first !== want.coeff_first)
                report($sformatf("m=%0d n=%0d coeff_first got %0d want %0d",
                                 want.m, want.n, got_first, want.coeff_first));
            if (got_second !== want.coeff_second)
                report($sformatf("m=%0d n=%0d coeff_second got %0d want %0d",
                                 want.m, want.n, got_second, want.coeff_second));
            if (got_steps !== want.steps)
                report($sformatf("m=%0d n=%0d step_count got %0d want %0d",
                                 want.m, want.n, got_steps, want.steps));
            if (got_pad !== 1'b0)
                report($sformatf("m=%0d n=%0d padding bit is %b", want.m, want.n, got_pad));
        endtask

        function int unsigned outstanding();
            return pending_bezout.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    egcd_scoreboard bezout_book = new();
    int unsigned    burst_left = 0;
    int unsigned    requests_sent = 0;

    extended_gcd_bezout_core #(
        .OPERAND_WIDTH(OPND_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Monitors: every handshake is sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            bezout_book.note_request(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            bezout_book.check_result(m_tdata);
    end

    // Receiver: alternates between always ready, short random stalls and long stalls.
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(500, 3000);
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready = 1'b1;
            case (stall_mode)
                1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 6);
                2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(5, 40);
                default: stall_left = 0;
            endcase
        end
    end

    // Sends one request in a burst; a new burst starts after a random gap.
    task send_operands(input logic [OPND_W-1:0] m, input logic [OPND_W-1:0] n);
        int unsigned gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                4, 5, 6, 7, 8: gap = $urandom_range(1, 8);
                default: gap = $urandom_range(20, 120);
            endcase
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                s_tdata = $urandom;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tdata = {n, m};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
        requests_sent++;
    endtask

    // Pair of consecutive Fibonacci numbers: the longest division chains.
    function automatic void fibonacci_pair(input int unsigned k,
                                           output logic [OPND_W-1:0] lo,
                                           output logic [OPND_W-1:0] hi);
        int unsigned f0;
        int unsigned f1;
        int unsigned nxt;
        f0 = 1;
        f1 = 1;
        for (int unsigned i = 2; i < k; i++)
        begin
            nxt = f0 + f1;
            f0 = f1;
            f1 = nxt;
        end
        lo = OPND_W'(f0);
        hi = OPND_W'(f1);
    endfunction

    // Random operand pair, biased toward long chains and the corner cases.
    task pick_operands(output logic [OPND_W-1:0] m, output logic [OPND_W-1:0] n);
        int unsigned kind;
        int unsigned base;
        int unsigned scale;
        logic [OPND_W-1:0] lo;
        logic [OPND_W-1:0] hi;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            m = OPND_W'($urandom);
            n = OPND_W'($urandom);
        end
        else if (kind < 45)
        begin
            fibonacci_pair($urandom_range(5, 24), lo, hi);
            scale = $urandom_range(1, 65535 / hi);
            if ($urandom_range(0, 1) == 0)
            begin
                m = OPND_W'(hi * scale);
                n = OPND_W'(lo * scale);
            end
            else
            begin
                m = OPND_W'(lo * scale);
                n = OPND_W'(hi * scale);
            end
        end
        else if (kind < 60)
        begin
            // The divisor goes evenly into the dividend.
            base = $urandom_range(1, 4000);
            n = OPND_W'(base);
            m = OPND_W'(base * $urandom_range(0, 65535 / base));
        end
        else if (kind < 75)
        begin
            m = OPND_W'($urandom_range(0, 31));
            n = OPND_W'($urandom_range(0, 31));
        end
        else if (kind < 85)
        begin
            base = $urandom_range(2, 255);
            m = OPND_W'(base * $urandom_range(1, 65535 / base));
            n = OPND_W'(base * $urandom_range(1, 65535 / base));
        end
        else if (kind < 90)
        begin
            m = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
            n = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        end
        else
        begin
            m = OPND_W'(16'hFFFF - $urandom_range(0, 255));
            n = OPND_W'(16'hFFFF - $urandom_range(0, 4095));
        end
    endtask

    // Run ends at the cycle limit if the traffic never drains.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results still due",
                 CYCLE_LIMIT, bezout_book.outstanding());
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed corners, random traffic, drain.
    initial
    begin
        logic [OPND_W-1:0] m;
        logic [OPND_W-1:0] n;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, zero operands, divisibility, swap and longest chains.
        send_operands(16'd1, 16'd1);
        send_operands(16'd65535, 16'd65535);
        send_operands(16'd65535, 16'd1);
        send_operands(16'd1, 16'd65535);
        send_operands(16'd0, 16'd5);
        send_operands(16'd5, 16'd0);
        send_operands(16'd0, 16'd0);
        send_operands(16'd65535, 16'd0);
        send_operands(16'd0, 16'd65535);
        send_operands(16'd100, 16'd10);
        send_operands(16'd12, 16'd18);
        send_operands(16'd48, 16'd18);
        send_operands(16'd17, 16'd5);
        send_operands(16'd46368, 16'd28657);
        send_operands(16'd28657, 16'd46368);
        send_operands(16'd65535, 16'd65534);
        send_operands(16'd65534, 16'd65535);
        send_operands(16'h8000, 16'h7FFF);
        send_operands(16'hAAAA, 16'h5555);
        send_operands(16'h5555, 16'hAAAA);
        send_operands(16'd3, 16'd65535);
        send_operands(16'd65521, 16'd65519);

        for (int unsigned i = 0; i < RANDOM_REQUESTS; i++)
        begin
            pick_operands(m, n);
            send_operands(m, n);
        end
        s_tvalid = 1'b0;

        while (bezout_book.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bezout_book.outstanding() != 0)
            bezout_book.report($sformatf("%0d results never arrived",
                                         bezout_book.outstanding()));

        $display("Sent %0d requests and checked %0d results; deepest chain %0d steps.",
                 requests_sent, bezout_book.results_checked, bezout_book.deepest_chain);
        $display("Requests with a zero operand: %0d; mismatches: %0d.",
                 bezout_book.zero_operand_cases, bezout_book.mismatches);
        if (bezout_book.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/egcd_pkg.sv
rtl/egcd_divider.sv
rtl/extended_gcd_bezout_core.sv
tb/tb.sv
